FILE: hdl/polygon_transform_about_centroid_core_macros.svh
// Assertion macros of the polygon transform checker.
`ifndef POLYGON_TRANSFORM_ABOUT_CENTROID_CORE_MACROS_SVH
`define POLYGON_TRANSFORM_ABOUT_CENTROID_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define PTC_ASSERT_IMPL(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define PTC_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/ptc_pkg.sv
// Types, constants and helper functions of the polygon transform block.
package ptc_pkg;

    localparam int MAX_POINTS_DEF   = 64;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ADDR_W           = 5;

    localparam logic signed [32:0] Q28_PI       = 33'sd843314857;
    localparam logic signed [32:0] Q28_NEG_PI   = -33'sd843314857;
    localparam logic signed [32:0] Q28_TWO_PI   = 33'sd1686629713;
    localparam logic signed [32:0] Q28_HALF_PI  = 33'sd421657428;
    localparam logic signed [32:0] Q28_NHALF_PI = -33'sd421657428;
    localparam logic signed [31:0] Q28_GAIN     = 32'sd163008218;

    localparam logic [1:0] MODE_MOVE   = 2'd0;
    localparam logic [1:0] MODE_ROTATE = 2'd1;
    localparam logic [1:0] MODE_SCALE  = 2'd2;

    localparam logic [2:0] REG_MODE       = 3'd0;
    localparam logic [2:0] REG_AMOUNT     = 3'd1;
    localparam logic [2:0] REG_TARGET_X   = 3'd2;
    localparam logic [2:0] REG_TARGET_Y   = 3'd3;
    localparam logic [2:0] REG_CENTER_X   = 3'd4;
    localparam logic [2:0] REG_CENTER_Y   = 3'd5;
    localparam logic [2:0] REG_USE_CENTER = 3'd6;

    typedef struct packed {
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic               last_point;
    } point_t;

    typedef struct packed {
        logic signed [23:0] out_x;
        logic signed [23:0] out_y;
        logic signed [23:0] used_center_x;
        logic signed [23:0] used_center_y;
        logic               out_last;
    } result_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] amount;
        logic signed [23:0] target_x;
        logic signed [23:0] target_y;
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic signed [23:0] mx;
        logic signed [23:0] my;
        logic signed [31:0] cs;
        logic signed [31:0] sn;
    } xf_ctrl_t;

    function automatic logic signed [31:0] atan_q28(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:    v = 32'sd210828714;
            5'd1:    v = 32'sd124459457;
            5'd2:    v = 32'sd65760959;
            5'd3:    v = 32'sd33381290;
            5'd4:    v = 32'sd16755422;
            5'd5:    v = 32'sd8385879;
            5'd6:    v = 32'sd4193963;
            5'd7:    v = 32'sd2097109;
            5'd8:    v = 32'sd1048571;
            5'd9:    v = 32'sd524287;
            5'd10:   v = 32'sd262144;
            5'd11:   v = 32'sd131072;
            5'd12:   v = 32'sd65536;
            5'd13:   v = 32'sd32768;
            5'd14:   v = 32'sd16384;
            5'd15:   v = 32'sd8192;
            5'd16:   v = 32'sd4096;
            5'd17:   v = 32'sd2048;
            5'd18:   v = 32'sd1024;
            5'd19:   v = 32'sd512;
            5'd20:   v = 32'sd256;
            5'd21:   v = 32'sd128;
            5'd22:   v = 32'sd64;
            5'd23:   v = 32'sd32;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
        logic signed [23:0] r;
        if (v > 32'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -32'sd8388608)
            r = 24'sh800000;
        else
            r = v[23:0];
        return r;
    endfunction

endpackage

FILE: hdl/ptc_vstore.sv
// Vertex store: one write port, one read port with registered data.
module ptc_vstore #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int W     = 48
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0]  rd_data
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/ptc_div.sv
// Restoring divider, one quotient bit a cycle, truncating toward zero.
module ptc_div #(
    parameter int SUM_W = 30,
    parameter int DEN_W = 7
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [DEN_W-1:0]        divisor,
    output logic                    busy,
    output logic signed [23:0]      quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             run_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [SUM_W-1:0] quo_reg;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             fits;
    logic [DEN_W-1:0] rem_next;
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] q_full;

    assign mag      = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
    assign rem_sh   = {rem_reg, quo_reg[SUM_W-1]};
    assign fits     = rem_sh >= {1'b0, den_reg};
    assign rem_sub  = rem_sh - {1'b0, den_reg};
    assign rem_next = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    assign q_full   = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient = q_full[23:0];
    assign busy     = run_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            cnt_reg <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SUM_W - 1))
            begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[SUM_W-1];
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= mag;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
        end
    end

endmodule

FILE: hdl/ptc_cordic.sv
// Iterative CORDIC: cosine and sine in Q.28, one rotation a cycle.
module ptc_cordic #(
    parameter int STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] angle,
    output logic               busy,
    output logic signed [31:0] cs,
    output logic signed [31:0] sn
);

    localparam int I_W = $clog2(STEPS);

    logic               run_reg;
    logic [I_W-1:0]     i_reg;
    logic               flip_reg;
    logic signed [31:0] x_reg;
    logic signed [31:0] y_reg;
    logic signed [31:0] z_reg;

    logic signed [32:0] z_raw;
    logic signed [32:0] z_red;
    logic signed [32:0] z_fl;
    logic               flip;
    logic signed [31:0] xs;
    logic signed [31:0] ys;
    logic signed [31:0] at;

    assign z_raw = $signed({angle[15], angle, 16'd0});

    always_comb
    begin
        if (z_raw >= ptc_pkg::Q28_PI)
            z_red = z_raw - ptc_pkg::Q28_TWO_PI;
        else if (z_raw < ptc_pkg::Q28_NEG_PI)
            z_red = z_raw + ptc_pkg::Q28_TWO_PI;
        else
            z_red = z_raw;
        flip = 1'b0;
        z_fl = z_red;
        if (z_red > ptc_pkg::Q28_HALF_PI)
        begin
            z_fl = z_red - ptc_pkg::Q28_PI;
            flip = 1'b1;
        end
        else if (z_red < ptc_pkg::Q28_NHALF_PI)
        begin
            z_fl = z_red + ptc_pkg::Q28_PI;
            flip = 1'b1;
        end
    end

    assign xs   = x_reg >>> i_reg;
    assign ys   = y_reg >>> i_reg;
    assign at   = ptc_pkg::atan_q28(5'(i_reg));
    assign busy = run_reg;
    assign cs   = flip_reg ? -x_reg : x_reg;
    assign sn   = flip_reg ? -y_reg : y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            i_reg   <= '0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            i_reg   <= '0;
        end
        else if (run_reg)
        begin
            i_reg <= i_reg + 1'b1;
            if (i_reg == I_W'(STEPS - 1))
            begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= ptc_pkg::Q28_GAIN;
            y_reg    <= '0;
            z_reg    <= z_fl[31:0];
            flip_reg <= flip;
        end
        else if (run_reg)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

endmodule

FILE: hdl/ptc_xform.sv
// Per-vertex datapath: registered products, then round, offset and saturate.
module ptc_xform (
    input  logic               clk,
    input  logic               go,
    input  logic signed [23:0] px,
    input  logic signed [23:0] py,
    input  ptc_pkg::xf_ctrl_t  ctrl,
    output logic signed [23:0] res_x,
    output logic signed [23:0] res_y
);

    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic signed [31:0] op1;
    logic signed [56:0] pa_c;
    logic signed [56:0] pb_c;
    logic signed [56:0] pc_c;
    logic signed [56:0] pd_c;
    logic signed [25:0] mvx_c;
    logic signed [25:0] mvy_c;

    logic signed [56:0] pa_reg;
    logic signed [56:0] pb_reg;
    logic signed [56:0] pc_reg;
    logic signed [56:0] pd_reg;
    logic signed [25:0] mvx_reg;
    logic signed [25:0] mvy_reg;
    logic signed [23:0] px_reg;
    logic signed [23:0] py_reg;

    logic signed [57:0] rot_x;
    logic signed [57:0] rot_y;
    logic signed [57:0] sc_x;
    logic signed [57:0] sc_y;
    logic signed [31:0] ox;
    logic signed [31:0] oy;

    assign dx    = 25'(px) - 25'(ctrl.cx);
    assign dy    = 25'(py) - 25'(ctrl.cy);
    assign op1   = (ctrl.mode == ptc_pkg::MODE_ROTATE) ? ctrl.cs : 32'(ctrl.amount);
    assign pa_c  = 57'(dx) * 57'(op1);
    assign pb_c  = 57'(dy) * 57'(ctrl.sn);
    assign pc_c  = 57'(dx) * 57'(ctrl.sn);
    assign pd_c  = 57'(dy) * 57'(op1);
    assign mvx_c = 26'(px) + 26'(ctrl.target_x) - 26'(ctrl.mx);
    assign mvy_c = 26'(py) + 26'(ctrl.target_y) - 26'(ctrl.my);

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            pa_reg  <= pa_c;
            pb_reg  <= pb_c;
            pc_reg  <= pc_c;
            pd_reg  <= pd_c;
            mvx_reg <= mvx_c;
            mvy_reg <= mvy_c;
            px_reg  <= px;
            py_reg  <= py;
        end
    end

    assign rot_x = 58'(pa_reg) - 58'(pb_reg) + 58'sd134217728;
    assign rot_y = 58'(pc_reg) + 58'(pd_reg) + 58'sd134217728;
    assign sc_x  = 58'(pa_reg) + 58'sd2048;
    assign sc_y  = 58'(pd_reg) + 58'sd2048;

    always_comb
    begin
        case (ctrl.mode)
            ptc_pkg::MODE_MOVE:
            begin
                ox = 32'(mvx_reg);
                oy = 32'(mvy_reg);
            end
            ptc_pkg::MODE_ROTATE:
            begin
                ox = 32'($signed(rot_x[57:28])) + 32'(ctrl.cx);
                oy = 32'($signed(rot_y[57:28])) + 32'(ctrl.cy);
            end
            ptc_pkg::MODE_SCALE:
            begin
                ox = $signed(sc_x[43:12]) + 32'(ctrl.cx);
                oy = $signed(sc_y[43:12]) + 32'(ctrl.cy);
            end
            default:
            begin
                ox = 32'(px_reg);
                oy = 32'(py_reg);
            end
        endcase
    end

    assign res_x = ptc_pkg::sat24(ox);
    assign res_y = ptc_pkg::sat24(oy);

endmodule

FILE: hdl/polygon_transform_about_centroid_core.sv
// A closing vertex leads to CALC_START and CALC_WAIT, then EMIT_RD, EMIT_MUL and EMIT_OUT for each result.
// Vertices load one a cycle, stalled outside the load state; each result passes store read, multiply and output.
// The centroid divider sets the set-up time (one quotient bit a cycle); the CORDIC runs alongside it.
// Reset: control and configuration registers to zero, store empty; store contents stay undefined.
// Vertices beyond MAX_POINTS are dropped; a dropped closing vertex still closes the polygon.
module polygon_transform_about_centroid_core #(
    parameter int MAX_POINTS   = ptc_pkg::MAX_POINTS_DEF,
    parameter int CORDIC_STEPS = ptc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       point_in_valid,
    output logic                       point_in_stall,
    input  ptc_pkg::point_t            point_in,
    output logic                       result_valid,
    input  logic                       result_stall,
    output ptc_pkg::result_t           result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ptc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int SUM_W = 24 + $clog2(MAX_POINTS);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CALC_START,
        ST_CALC_WAIT,
        ST_EMIT_RD,
        ST_EMIT_MUL,
        ST_EMIT_OUT
    } state_t;

    // Configuration registers.
    logic [1:0]         mode_reg;
    logic signed [15:0] amount_reg;
    logic signed [23:0] target_x_reg;
    logic signed [23:0] target_y_reg;
    logic signed [23:0] center_x_reg;
    logic signed [23:0] center_y_reg;
    logic               use_center_reg;

    state_t                  state_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        n_reg;
    logic [CNT_W-1:0]        k_reg;
    logic signed [SUM_W-1:0] sum_x_reg;
    logic signed [SUM_W-1:0] sum_y_reg;
    logic signed [23:0]      cx_reg;
    logic signed [23:0]      cy_reg;
    logic signed [23:0]      mx_reg;
    logic signed [23:0]      my_reg;
    logic                    out_valid_reg;
    ptc_pkg::result_t        out_reg;

    logic               in_accept;
    logic               has_room;
    logic               out_free;
    logic               k_last;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic               div_start;
    logic               div_x_busy;
    logic               div_y_busy;
    logic               cordic_busy;
    logic signed [23:0] mean_x;
    logic signed [23:0] mean_y;
    logic signed [31:0] cs;
    logic signed [31:0] sn;
    logic               use_given;
    logic [47:0]        rd_data;
    logic signed [23:0] res_x;
    logic signed [23:0] res_y;
    ptc_pkg::xf_ctrl_t  ctrl;

    assign pready         = 1'b1;
    assign point_in_stall = (state_reg != ST_LOAD);
    assign in_accept      = point_in_valid && !point_in_stall;
    assign has_room       = count_reg < CNT_W'(MAX_POINTS);
    assign out_free       = !out_valid_reg || !result_stall;
    assign k_last         = (k_reg + 1'b1) == n_reg;
    assign div_start      = (state_reg == ST_CALC_START);
    assign cfg_index      = paddr[ptc_pkg::ADDR_W-1:2];
    assign cfg_write      = psel && penable && pwrite;
    assign use_given      = (mode_reg != ptc_pkg::MODE_MOVE) && use_center_reg;
    assign result_valid   = out_valid_reg;
    assign result         = out_reg;

    // Register readback.
    always_comb
    begin
        case (cfg_index)
            ptc_pkg::REG_MODE:       prdata = {30'd0, mode_reg};
            ptc_pkg::REG_AMOUNT:     prdata = {16'd0, amount_reg};
            ptc_pkg::REG_TARGET_X:   prdata = {8'd0, target_x_reg};
            ptc_pkg::REG_TARGET_Y:   prdata = {8'd0, target_y_reg};
            ptc_pkg::REG_CENTER_X:   prdata = {8'd0, center_x_reg};
            ptc_pkg::REG_CENTER_Y:   prdata = {8'd0, center_y_reg};
            ptc_pkg::REG_USE_CENTER: prdata = {31'd0, use_center_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    // Register writes; an index past the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= '0;
            amount_reg     <= '0;
            target_x_reg   <= '0;
            target_y_reg   <= '0;
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            use_center_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ptc_pkg::REG_MODE:       mode_reg       <= pwdata[1:0];
                ptc_pkg::REG_AMOUNT:     amount_reg     <= pwdata[15:0];
                ptc_pkg::REG_TARGET_X:   target_x_reg   <= pwdata[23:0];
                ptc_pkg::REG_TARGET_Y:   target_y_reg   <= pwdata[23:0];
                ptc_pkg::REG_CENTER_X:   center_x_reg   <= pwdata[23:0];
                ptc_pkg::REG_CENTER_Y:   center_y_reg   <= pwdata[23:0];
                ptc_pkg::REG_USE_CENTER: use_center_reg <= pwdata[0];
                default:                 ;
            endcase
        end
    end

    // Vertex store: write at the fill count, replay by the emit index.
    ptc_vstore #(
        .DEPTH (MAX_POINTS),
        .AW    (AW),
        .W     (48)
    ) u_vstore (
        .clk     (clk),
        .wr_en   (in_accept && has_room),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({point_in.point_x, point_in.point_y}),
        .rd_en   (state_reg == ST_EMIT_RD),
        .rd_addr (k_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // Centroid dividers, one per axis, started together.
    ptc_div #(
        .SUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_x_reg),
        .divisor  (n_reg),
        .busy     (div_x_busy),
        .quotient (mean_x)
    );

    ptc_div #(
        .SUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_y_reg),
        .divisor  (n_reg),
        .busy     (div_y_busy),
        .quotient (mean_y)
    );

    // Sine and cosine of the configured angle, run beside the dividers.
    ptc_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .angle (amount_reg),
        .busy  (cordic_busy),
        .cs    (cs),
        .sn    (sn)
    );

    always_comb
    begin
        ctrl.mode     = mode_reg;
        ctrl.amount   = amount_reg;
        ctrl.target_x = target_x_reg;
        ctrl.target_y = target_y_reg;
        ctrl.cx       = cx_reg;
        ctrl.cy       = cy_reg;
        ctrl.mx       = mx_reg;
        ctrl.my       = my_reg;
        ctrl.cs       = cs;
        ctrl.sn       = sn;
    end

    ptc_xform u_xform (
        .clk   (clk),
        .go    (state_reg == ST_EMIT_MUL),
        .px    ($signed(rd_data[47:24])),
        .py    ($signed(rd_data[23:0])),
        .ctrl  (ctrl),
        .res_x (res_x),
        .res_y (res_y)
    );

    // Sequencer: load, set up the centre, replay the store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Drop the held result once the far side takes it, unless a new one replaces it.
            if (out_valid_reg && !result_stall && (state_reg != ST_EMIT_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD:
                begin
                    if (in_accept)
                    begin
                        if (has_room)
                        begin
                            count_reg <= count_reg + 1'b1;
                            sum_x_reg <= sum_x_reg + SUM_W'(point_in.point_x);
                            sum_y_reg <= sum_y_reg + SUM_W'(point_in.point_y);
                        end
                        if (point_in.last_point)
                        begin
                            n_reg     <= has_room ? count_reg + 1'b1 : count_reg;
                            state_reg <= ST_CALC_START;
                        end
                    end
                end
                ST_CALC_START:
                begin
                    state_reg <= ST_CALC_WAIT;
                end
                ST_CALC_WAIT:
                begin
                    if (!div_x_busy && !div_y_busy && !cordic_busy)
                    begin
                        count_reg <= '0;
                        sum_x_reg <= '0;
                        sum_y_reg <= '0;
                        k_reg     <= '0;
                        state_reg <= ST_EMIT_RD;
                    end
                end
                ST_EMIT_RD:
                begin
                    state_reg <= ST_EMIT_MUL;
                end
                ST_EMIT_MUL:
                begin
                    state_reg <= ST_EMIT_OUT;
                end
                ST_EMIT_OUT:
                begin
                    // Hold until the output register is free, then advance.
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        k_reg         <= k_reg + 1'b1;
                        state_reg     <= k_last ? ST_LOAD : ST_EMIT_RD;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // Centre capture and result payload.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CALC_WAIT)
        begin
            mx_reg <= mean_x;
            my_reg <= mean_y;
            cx_reg <= use_given ? center_x_reg : mean_x;
            cy_reg <= use_given ? center_y_reg : mean_y;
        end
        if (state_reg == ST_EMIT_OUT && out_free)
        begin
            out_reg.out_x         <= res_x;
            out_reg.out_y         <= res_y;
            out_reg.used_center_x <= cx_reg;
            out_reg.used_center_y <= cy_reg;
            out_reg.out_last      <= k_last;
        end
    end

endmodule

FILE: hdl/ptc_chk.sv
// Port-level checker of the polygon transform block and its bind.
`include "polygon_transform_about_centroid_core_macros.svh"

module ptc_chk (
    input logic             clk,
    input logic             rst_n,
    input logic             point_in_valid,
    input logic             point_in_stall,
    input ptc_pkg::point_t  point_in,
    input logic             result_valid,
    input logic             result_stall,
    input ptc_pkg::result_t result,
    input logic             pready
);

    logic in_acc;

    assign in_acc = point_in_valid && !point_in_stall;

    `PTC_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))
    `PTC_ASSERT_IMPL(a_pready_high, 1'b1, pready)
    `PTC_ASSERT_NEXT(a_close_stalls, in_acc && point_in.last_point, point_in_stall)
    `PTC_ASSERT_NEXT(a_no_early_result, in_acc, !$rose(result_valid))

endmodule

bind polygon_transform_about_centroid_core ptc_chk u_ptc_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .point_in_valid (point_in_valid),
    .point_in_stall (point_in_stall),
    .point_in       (point_in),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result),
    .pready         (pready)
);

FILE: tb/tb_polygon_transform_about_centroid_core.sv
// Testbench of the polygon transform core: random polygons checked against a local predictor.
module tb_polygon_transform_about_centroid_core;
    import ptc_pkg::*;

    // Predicted results in arrival order, compared with what the core emits.
    class vertex_scoreboard;
        result_t expected_q[$];
        int errors;
        logic [1:0] mode;
        longint amount, target_x, target_y, center_x, center_y;
        bit use_center;
        longint store_x[64];
        longint store_y[64];
        int count;
        longint sum_x, sum_y;

        function new();
            errors = 0;
            count = 0;
            sum_x = 0;
            sum_y = 0;
            mode = MODE_MOVE;
            amount = 0;
            target_x = 0;
            target_y = 0;
            center_x = 0;
            center_y = 0;
            use_center = 0;
        endfunction

        function longint floor_shr(longint v, int s);
            return v >>> s;
        endfunction

        function longint clamp24(longint v);
            if (v > 8388607)
                return 8388607;
            if (v < -8388608)
                return -8388608;
            return v;
        endfunction

        function void sincos(output longint c, output longint s);
            longint z, x, y, nx;
            longint atan_tab[16];
            bit flip;
            atan_tab = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
                         4193963, 2097109, 1048571, 524287, 262144, 131072, 65536,
                         32768, 16384, 8192};
            z = amount * 65536;
            x = 163008218;
            y = 0;
            flip = 0;
            while (z >= 843314857)
                z -= 1686629713;
            while (z < -843314857)
                z += 1686629713;
            if (z > 421657428)
            begin
                z -= 843314857;
                flip = 1;
            end
            else if (z < -421657428)
            begin
                z += 843314857;
                flip = 1;
            end
            for (int i = 0; i < CORDIC_STEPS_DEF; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - floor_shr(y, i);
                    y = y + floor_shr(x, i);
                    z -= atan_tab[i];
                end
                else
                begin
                    nx = x + floor_shr(y, i);
                    y = y - floor_shr(x, i);
                    z += atan_tab[i];
                end
                x = nx;
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            c = x;
            s = y;
        endfunction

        // Note an accepted vertex; on a closing vertex push the whole polygon.
        function void note_point(point_t p);
            longint mx, my, cx, cy, cs, sn, dx, dy, ox, oy;
            result_t r;
            if (count < MAX_POINTS_DEF)
            begin
                store_x[count] = p.point_x;
                store_y[count] = p.point_y;
                count++;
                sum_x += p.point_x;
                sum_y += p.point_y;
            end
            if (!p.last_point || count == 0)
                return;
            mx = sum_x / count;
            my = sum_y / count;
            cs = 0;
            sn = 0;
            if (mode != MODE_MOVE && use_center)
            begin
                cx = center_x;
                cy = center_y;
            end
            else
            begin
                cx = mx;
                cy = my;
            end
            if (mode == MODE_ROTATE)
                sincos(cs, sn);
            for (int k = 0; k < count; k++)
            begin
                dx = store_x[k] - cx;
                dy = store_y[k] - cy;
                case (mode)
                    MODE_MOVE:
                    begin
                        ox = store_x[k] + target_x - mx;
                        oy = store_y[k] + target_y - my;
                    end
                    MODE_ROTATE:
                    begin
                        ox = cx + floor_shr(dx * cs - dy * sn + (64'sd1 <<< 27), 28);
                        oy = cy + floor_shr(dx * sn + dy * cs + (64'sd1 <<< 27), 28);
                    end
                    MODE_SCALE:
                    begin
                        ox = cx + floor_shr(dx * amount + 2048, 12);
                        oy = cy + floor_shr(dy * amount + 2048, 12);
                    end
                    default:
                    begin
                        ox = store_x[k];
                        oy = store_y[k];
                    end
                endcase
                r.out_x = clamp24(ox);
                r.out_y = clamp24(oy);
                r.used_center_x = cx;
                r.used_center_y = cy;
                r.out_last = (k + 1 == count);
                expected_q.push_back(r);
            end
            count = 0;
            sum_x = 0;
            sum_y = 0;
        endfunction

        function void check_result(result_t a);
            result_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result %h", a);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (a.out_x !== e.out_x)
            begin
                $error("out_x expected %0d actual %0d", e.out_x, a.out_x);
                errors++;
            end
            if (a.out_y !== e.out_y)
            begin
                $error("out_y expected %0d actual %0d", e.out_y, a.out_y);
                errors++;
            end
            if (a.used_center_x !== e.used_center_x)
            begin
                $error("used_center_x expected %0d actual %0d",
                       e.used_center_x, a.used_center_x);
                errors++;
            end
            if (a.used_center_y !== e.used_center_y)
            begin
                $error("used_center_y expected %0d actual %0d",
                       e.used_center_y, a.used_center_y);
                errors++;
            end
            if (a.out_last !== e.out_last)
            begin
                $error("out_last expected %0d actual %0d", e.out_last, a.out_last);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic point_in_valid = 0;
    logic point_in_stall;
    point_t point_in = '0;
    logic result_valid;
    logic result_stall = 0;
    result_t result;
    logic psel = 0;
    logic penable = 0;
    logic pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    vertex_scoreboard polygon_sb = new();

    // Idle control: percent chance of a gap, zero during the calm stretch.
    int send_idle_pct = 28;
    int recv_idle_pct = 28;
    bit hold_results = 0;
    int quiet_cycles = 0;

    always #10 clk = ~clk;

    polygon_transform_about_centroid_core i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .point_in_valid(point_in_valid),
        .point_in_stall(point_in_stall),
        .point_in(point_in),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // Sample results and the input handshake at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                polygon_sb.check_result(result);
            if ((result_valid && !result_stall) || (point_in_valid && !point_in_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Drive the result stall at the falling edge; hold it high while the long hold-off runs.
    always @(negedge clk)
    begin
        result_stall <= hold_results || ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog: end the run when nothing moves for far too long.
    always @(posedge clk)
    begin
        if (quiet_cycles > 20000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Write one register: setup phase, then access phase.
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= value;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            REG_MODE:       polygon_sb.mode = value[1:0];
            REG_AMOUNT:     polygon_sb.amount = $signed(value[15:0]);
            REG_TARGET_X:   polygon_sb.target_x = $signed(value[23:0]);
            REG_TARGET_Y:   polygon_sb.target_y = $signed(value[23:0]);
            REG_CENTER_X:   polygon_sb.center_x = $signed(value[23:0]);
            REG_CENTER_Y:   polygon_sb.center_y = $signed(value[23:0]);
            REG_USE_CENTER: polygon_sb.use_center = value[0];
            default: ;
        endcase
    endtask

    // Offer one vertex, with a random gap before it, and hold it until accepted.
    // Return at the falling edge after acceptance; the caller drives valid next.
    task automatic send_point(logic signed [23:0] x, logic signed [23:0] y, bit last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            point_in_valid <= 0;
            @(negedge clk);
        end
        point_in_valid <= 1;
        point_in <= '{point_x: x, point_y: y, last_point: last};
        @(posedge clk);
        while (point_in_stall)
            @(posedge clk);
        polygon_sb.note_point('{point_x: x, point_y: y, last_point: last});
        @(negedge clk);
    endtask

    // Wait until every predicted result is in, then let the core settle.
    task automatic drain();
        point_in_valid <= 0;
        while (polygon_sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    function automatic logic signed [23:0] rand_coord(int kind);
        case (kind)
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return $signed(24'($urandom()));
            default: return $signed(24'($urandom_range(8191))) - 24'sd4096;
        endcase
    endfunction

    // Send one polygon of n vertices with random content.
    task automatic send_polygon(int n, int wide);
        for (int i = 0; i < n; i++)
            send_point(rand_coord(wide ? $urandom_range(3) : 3),
                       rand_coord(wide ? $urandom_range(3) : 3), i == n - 1);
    endtask

    // Apply one random setting of all registers.
    task automatic random_config();
        write_reg(REG_MODE, $urandom_range(3));
        write_reg(REG_AMOUNT, $urandom());
        write_reg(REG_TARGET_X, $urandom());
        write_reg(REG_TARGET_Y, $urandom());
        write_reg(REG_CENTER_X, $urandom());
        write_reg(REG_CENTER_Y, $urandom());
        write_reg(REG_USE_CENTER, $urandom_range(1));
    endtask

    int sent;

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Directed: extremes in move mode with the reset setting.
        send_point(24'sh7FFFFF, 24'sh800000, 0);
        send_point(24'sh800000, 24'sh7FFFFF, 1);
        send_point(24'sd0, 24'sd0, 1);
        drain();
        // Rotate by pi about a given centre, saturating far points.
        write_reg(REG_MODE, MODE_ROTATE);
        write_reg(REG_AMOUNT, 32'h3244);
        write_reg(REG_CENTER_X, 32'h00800000);
        write_reg(REG_CENTER_Y, 32'h007FFFFF);
        write_reg(REG_USE_CENTER, 1);
        send_point(24'sh7FFFFF, 24'sh7FFFFF, 0);
        send_point(-24'sd256, 24'sd512, 1);
        drain();
        // Scale by the most negative factor about the centroid.
        write_reg(REG_MODE, MODE_SCALE);
        write_reg(REG_AMOUNT, 32'h8000);
        write_reg(REG_USE_CENTER, 0);
        send_point(24'sd1000, -24'sd1000, 0);
        send_point(24'sh7FFFFF, 24'sh800000, 1);
        drain();
        // Unused mode value passes vertices through.
        write_reg(REG_MODE, 3);
        write_reg(REG_TARGET_X, 32'h007FFFFF);
        write_reg(REG_TARGET_Y, 32'h00800000);
        send_point(24'sd5, 24'sd7, 1);
        drain();
        // Full store: overflow vertices are dropped, the dropped last one still closes.
        write_reg(REG_MODE, MODE_MOVE);
        send_polygon(66, 1);
        drain();

        // Long receiver hold-off while the sender keeps offering vertices.
        fork
            begin
                hold_results = 1;
                repeat (400) @(negedge clk);
                hold_results = 0;
            end
            begin
                send_idle_pct = 0;
                repeat (4) send_polygon(8, 0);
                send_idle_pct = 28;
            end
        join
        drain();

        sent = 0;
        while (sent < 190)
        begin
            int n;
            random_config();
            for (int p = 0; p < 4; p++)
            begin
                n = ($urandom_range(19) == 0) ? $urandom_range(64, 66) : $urandom_range(1, 8);
                // A calm stretch with no idling on either side.
                if (sent > 120 && sent < 170)
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                else
                begin
                    send_idle_pct = 28;
                    recv_idle_pct = 28;
                end
                send_polygon(n, $urandom_range(1));
                sent += n;
            end
            // Pause the sender until every result is in before reconfiguring.
            drain();
        end

        if (polygon_sb.errors == 0 && polygon_sb.expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
